@@ sv/prq_pkg.sv @@
// Package for the priority ready queue: sizes, entry type, op and status codes,
// sequencer states and the priority clamp. No dependencies.
`default_nettype none

package prq_pkg;

	localparam int DEPTH       = 16;
	localparam int PRIO_LEVELS = 4;
	localparam int ID_BITS     = 8;

	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int PRIO_W     = $clog2(PRIO_LEVELS);
	localparam int OP_W       = 2;
	localparam int TID_W      = 8;
	localparam int PRIO_IO_W  = 2;
	localparam int OCC_W      = 5;
	localparam int STATUS_W   = 2;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [PRIO_W-1:0]  prio;
	} prq_entry_t;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_QUERY  = 2'd2
	} prq_op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} prq_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_PLACE,
		S_DONE
	} prq_state_t;

	function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_IO_W-1:0] p);
		if (32'(p) >= 32'(PRIO_LEVELS))
			return PRIO_W'(PRIO_LEVELS - 1);
		return PRIO_W'(p);
	endfunction

endpackage

`default_nettype wire

@@ sv/prq_req_if.sv @@
// Request channel of the priority ready queue: valid/ready plus op, tid, prio.
// Depends on prq_pkg.
`default_nettype none

interface prq_req_if;
	import prq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [TID_W-1:0]     tid;
	logic [PRIO_IO_W-1:0] prio;

	modport source (output valid, op, tid, prio, input ready);
	modport sink   (input valid, op, tid, prio, output ready);
endinterface

`default_nettype wire

@@ sv/prq_rsp_if.sv @@
// Response channel of the priority ready queue: valid/ready plus result word.
// Depends on prq_pkg.
`default_nettype none

interface prq_rsp_if;
	import prq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [TID_W-1:0]     out_tid;
	logic [PRIO_IO_W-1:0] out_prio;
	logic                 found;
	logic [STATUS_W-1:0]  status;
	logic [OCC_W-1:0]     occupancy;

	modport source (output valid, out_tid, out_prio, found, status, occupancy, input ready);
	modport sink   (input valid, out_tid, out_prio, found, status, occupancy, output ready);
endinterface

`default_nettype wire

@@ sv/priority_ready_queue.sv @@
// Priority ready queue top level: entry memory, walking sequencer, result register.
// Depends on prq_pkg, prq_req_if and prq_rsp_if.
//
// Stable priority queue of up to DEPTH (id, priority) entries, head at slot 0, lower
// priority number served first, equal priorities in arrival order. One request word is
// taken at a time; req.ready is high only while the sequencer is idle. The entry store is
// a single memory with one write and one registered read port, so every entry visited
// takes a read state and then an act state. Insert walks from the tail towards the head,
// moving each lower-priority entry up by one, and stops at an entry that stays. Pop
// returns slot 0 and moves the rest down. Query scans from the head until a hit or the
// tail. Full insert, empty pop, empty query and the unused op go straight to the result.
// The response sits in an output register, so the next request is accepted while an
// earlier response still waits for rsp.ready.
`default_nettype none

module priority_ready_queue (
	input  wire        clk,
	input  wire        arst_n,
	prq_req_if.sink    req,
	prq_rsp_if.source  rsp
);
	import prq_pkg::*;

	prq_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;

	prq_entry_t mem_q [DEPTH];
	prq_entry_t rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic             we;
	logic [IDX_W-1:0] wa;
	prq_entry_t       wd;

	logic [OP_W-1:0]    op_q;
	logic [ID_BITS-1:0] id_q;
	logic [PRIO_W-1:0]  pr_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   km1;
	prq_entry_t         hd_q;
	logic               found_q;
	prq_status_t        status_q;

	logic [TID_W-1:0]     out_tid_q;
	logic [PRIO_IO_W-1:0] out_prio_q;
	logic                 out_found_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [OCC_W-1:0]     out_occ_q;

	logic accept, greater, hit, last, emit, full, empty;

	assign km1     = k_q - CNT_W'(1);
	assign greater = rd_q.prio > pr_q;
	assign hit     = rd_q.id == id_q;
	assign last    = k_q == (count_q - CNT_W'(1));
	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign accept  = req.valid && req.ready;
	assign emit    = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					case (req.op)
						OP_INSERT: state_d = full ? S_DONE : (empty ? S_PLACE : S_READ);
						OP_POP,
						OP_QUERY:  state_d = empty ? S_DONE : S_READ;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_READ: state_d = S_EXEC;
			S_EXEC: begin
				case (op_q)
					OP_INSERT: state_d = (greater && k_q != CNT_W'(1)) ? S_READ : S_PLACE;
					OP_POP:    state_d = last ? S_DONE : S_READ;
					OP_QUERY:  state_d = (hit || last) ? S_DONE : S_READ;
					default:   state_d = S_DONE;
				endcase
			end
			S_PLACE: state_d = S_DONE;
			S_DONE:  state_d = emit ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and memory control
	always_comb begin
		req.ready = state_q == S_IDLE;
		rd_addr   = (op_q == OP_INSERT) ? km1[IDX_W-1:0] : k_q[IDX_W-1:0];
		we        = 1'b0;
		wa        = k_q[IDX_W-1:0];
		wd        = rd_q;
		case (state_q)
			S_EXEC: begin
				if (op_q == OP_INSERT && greater) begin
					we = 1'b1;
				end else if (op_q == OP_POP && k_q != '0) begin
					we = 1'b1;
					wa = km1[IDX_W-1:0];
				end
			end
			S_PLACE: begin
				we = 1'b1;
				wd = '{id: id_q, prio: pr_q};
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[wa] <= wd;
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_PLACE)
				count_q <= count_q + CNT_W'(1);
			else if (state_q == S_EXEC && op_q == OP_POP && last)
				count_q <= count_q - CNT_W'(1);
			if (emit)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req.op;
			id_q     <= ID_BITS'(req.tid);
			pr_q     <= clamp_prio(req.prio);
			k_q      <= (req.op == OP_INSERT) ? count_q : '0;
			hd_q     <= '0;
			found_q  <= 1'b0;
			status_q <= (req.op == OP_INSERT && full) ? STAT_FULL :
				((req.op == OP_POP && empty) ? STAT_EMPTY : STAT_OK);
		end else if (state_q == S_EXEC) begin
			case (op_q)
				OP_INSERT: begin
					if (greater)
						k_q <= km1;
				end
				OP_POP: begin
					if (k_q == '0)
						hd_q <= rd_q;
					k_q <= k_q + CNT_W'(1);
				end
				OP_QUERY: begin
					if (hit)
						found_q <= 1'b1;
					k_q <= k_q + CNT_W'(1);
				end
				default: k_q <= k_q;
			endcase
		end
		if (emit) begin
			out_tid_q    <= TID_W'(hd_q.id);
			out_prio_q   <= PRIO_IO_W'(hd_q.prio);
			out_found_q  <= found_q;
			out_status_q <= status_q;
			out_occ_q    <= OCC_W'(count_q);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.out_tid   = out_tid_q;
	assign rsp.out_prio  = out_prio_q;
	assign rsp.found     = out_found_q;
	assign rsp.status    = out_status_q;
	assign rsp.occupancy = out_occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STAT_FULL |-> rsp.occupancy == OCC_W'(DEPTH))
		else $error("full status without full queue");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STAT_EMPTY |-> rsp.occupancy == '0)
		else $error("empty status with entries present");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> CNT_W'(wa) <= count_q)
		else $error("write beyond occupied region");

endmodule

`default_nettype wire
